// File: rtl/core/ntamc_pkg.sv
// ----------------------------------------------------------------------------
// ntamc_pkg
// Shared types and constants for the neighbor table with aging and master
// check.
// ----------------------------------------------------------------------------
package ntamc_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAX_REPORTS       = 64;

  localparam logic [7:0] FMT_VERSION = 8'h02;
  localparam logic [7:0] RADIO_KIND  = 8'h01;
  localparam logic [7:0] MASTER_ON   = 8'h01;
  localparam logic [7:0] AGE_MAX     = 8'hFF;
  localparam logic [7:0] AGE_LIMIT_RST = 8'd3;

  // Configuration register indexes.
  localparam logic [2:0] R_NODE   = 3'd0;
  localparam logic [2:0] R_FREQ   = 3'd1;
  localparam logic [2:0] R_POWER  = 3'd2;
  localparam logic [2:0] R_MODE   = 3'd3;
  localparam logic [2:0] R_RATE   = 3'd4;
  localparam logic [2:0] R_MASTER = 3'd5;
  localparam logic [2:0] R_AGELIM = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PEER   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Probe status codes.
  localparam logic [2:0] ST_UNCHANGED = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_CHANGED   = 3'd2;
  localparam logic [2:0] ST_OWN       = 3'd3;
  localparam logic [2:0] ST_BADFMT    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Peer report reasons.
  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_MISMATCH = 2'd1;
  localparam logic [1:0] RS_NOMASTER = 2'd2;
  localparam logic [1:0] RS_MULTI    = 2'd3;

  // Table walk phases.
  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_AGE  = 2'd1;
  localparam logic [1:0] PH_RPT  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  format_version;
    logic [7:0]  radio_kind;
    logic [7:0]  node_no;
    logic [31:0] peer_ip;
    logic [15:0] radio_freq;
    logic [7:0]  radio_power;
    logic [7:0]  work_mode;
    logic [7:0]  radio_rate;
    logic [7:0]  master_byte;
    logic [47:0] src_mac;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  probe_status;
    logic [7:0]  peer_node;
    logic [31:0] peer_address;
    logic        reachable;
    logic [1:0]  reason;
    logic        aged_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [15:0] freq;
    logic [7:0]  power;
    logic [7:0]  mode;
    logic [7:0]  rate;
    logic [7:0]  master;
    logic [7:0]  age_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] addr;
    logic [15:0] freq;
    logic [7:0]  power;
    logic [7:0]  mode;
    logic [7:0]  rate;
    logic [7:0]  master;
    logic [47:0] mac;
    logic [7:0]  age;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic       issue;
    logic [1:0] phase;
    logic       clr_idx;
    logic       emit_early;
    logic       pwrite;
    logic       rpt_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic fmt_bad;
    logic own;
    logic issue_done;
    logic pipe_busy;
    logic rpt_full;
  } dp_sts_t;

endpackage

// File: rtl/core/neighbor_table_aging_master_check_unit.sv
// ----------------------------------------------------------------------------
// neighbor_table_aging_master_check_unit
// Neighbor table with aging and master check: register file and top level.
// ----------------------------------------------------------------------------
// A rejected probe shows its status in the result register after the check
// state; an accepted probe walks the table once, then writes its slot; a tick
// walks it twice, aging then reports, the last report ending the walk.
// Throughput: one item at a time, the next taken in the cycle the final result
// shows; the table memory's single read port sets it. Results cannot be stalled.
// Reset empties the table at once through its valid bits; no clearing pass.
module neighbor_table_aging_master_check_unit import ntamc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    wr_hit;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node      <= '0;
      cfg_r.freq      <= '0;
      cfg_r.power     <= '0;
      cfg_r.mode      <= '0;
      cfg_r.rate      <= '0;
      cfg_r.master    <= '0;
      cfg_r.age_limit <= AGE_LIMIT_RST;
    end else if (wr_hit) begin
      unique case (ridx)
        R_NODE:   cfg_r.node      <= pwdata[7:0];
        R_FREQ:   cfg_r.freq      <= pwdata[15:0];
        R_POWER:  cfg_r.power     <= pwdata[7:0];
        R_MODE:   cfg_r.mode      <= pwdata[7:0];
        R_RATE:   cfg_r.rate      <= pwdata[7:0];
        R_MASTER: cfg_r.master    <= pwdata[7:0];
        R_AGELIM: cfg_r.age_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (ridx)
      R_NODE:   prdata = {24'd0, cfg_r.node};
      R_FREQ:   prdata = {16'd0, cfg_r.freq};
      R_POWER:  prdata = {24'd0, cfg_r.power};
      R_MODE:   prdata = {24'd0, cfg_r.mode};
      R_RATE:   prdata = {24'd0, cfg_r.rate};
      R_MASTER: prdata = {24'd0, cfg_r.master};
      R_AGELIM: prdata = {24'd0, cfg_r.age_limit};
      default:  prdata = '0;
    endcase
  end

  ntamc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ntamc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/ntamc_dpath.sv
// ----------------------------------------------------------------------------
// ntamc_dpath
// Table memory, valid bits, walk pipeline, probe update, aging, master
// count and result register.
// ----------------------------------------------------------------------------
module ntamc_dpath import ntamc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int RCW = $clog2(MAX_REPORTS + 1);

  entry_t mem [TABLE_ENTRIES];

  in_item_t               item_r;
  logic [CW-1:0]          idx_r;
  logic                   s1_vld_r;
  logic [1:0]             s1_phase_r;
  logic [IW-1:0]          s1_idx_r;
  entry_t                 rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                   found_r;
  logic [IW-1:0]          slot_r;
  logic                   changed_r;
  logic                   free_ok_r;
  logic [IW-1:0]          free_r;
  logic                   aged_r;
  logic [1:0]             mcnt_r;
  logic [RCW-1:0]         rcnt_r;
  logic                   pend_v_r;
  out_item_t              pend_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  entry_t        probe_rec, age_rec, wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          ent_v, pmatch, expire, differs, full;
  logic [7:0]    age_inc;
  logic [1:0]    reason;
  out_item_t     peer_item;

  // Record that a probe writes into its slot.
  always_comb begin
    probe_rec.node   = item_r.node_no;
    probe_rec.addr   = item_r.peer_ip;
    probe_rec.freq   = item_r.radio_freq;
    probe_rec.power  = item_r.radio_power;
    probe_rec.mode   = item_r.work_mode;
    probe_rec.rate   = item_r.radio_rate;
    probe_rec.master = item_r.master_byte;
    probe_rec.mac    = item_r.src_mac;
    probe_rec.age    = '0;
  end

  // Per-entry evaluation of the record that the walk just read.
  always_comb begin
    ent_v   = valid_r[s1_idx_r];
    pmatch  = (rd_r.freq == cfg.freq) && (rd_r.power == cfg.power) &&
              (rd_r.mode == cfg.mode) && (rd_r.rate == cfg.rate);
    age_inc = (rd_r.age == AGE_MAX) ? AGE_MAX : rd_r.age + 8'd1;
    expire  = age_inc > cfg.age_limit;
    differs = (rd_r.addr != item_r.peer_ip) || (rd_r.freq != item_r.radio_freq) ||
              (rd_r.power != item_r.radio_power) || (rd_r.mode != item_r.work_mode) ||
              (rd_r.rate != item_r.radio_rate) || (rd_r.master != item_r.master_byte) ||
              (rd_r.mac != item_r.src_mac);
    full    = rcnt_r == RCW'(MAX_REPORTS);
    age_rec = rd_r;
    age_rec.age = age_inc;
    if (!pmatch)              reason = RS_MISMATCH;
    else if (mcnt_r == 2'd0)  reason = RS_NOMASTER;
    else if (mcnt_r > 2'd1)   reason = RS_MULTI;
    else                      reason = RS_OK;
    peer_item              = '0;
    peer_item.kind         = KIND_PEER;
    peer_item.peer_node    = rd_r.node;
    peer_item.peer_address = rd_r.addr;
    peer_item.reachable    = (reason == RS_OK);
    peer_item.reason       = reason;
    peer_item.aged_out     = aged_r;
  end

  // Memory write port: probe update or age write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = s1_idx_r;
    wr_data = age_rec;
    if (cmd.pwrite && (found_r || free_ok_r)) begin
      wr_en   = 1'b1;
      wr_idx  = found_r ? slot_r : free_r;
      wr_data = probe_rec;
    end else if (s1_vld_r && s1_phase_r == PH_AGE && ent_v && !expire) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (cmd.issue) rd_r <= mem[idx_r[IW-1:0]];
  end

  // Result selection.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    if (cmd.emit_early) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = KIND_STATUS;
      out_nxt.probe_status = sts.fmt_bad ? ST_BADFMT : ST_OWN;
      out_nxt.last         = 1'b1;
    end else if (cmd.pwrite) begin
      out_valid_nxt = 1'b1;
      out_nxt.kind  = KIND_STATUS;
      out_nxt.last  = 1'b1;
      if (found_r)        out_nxt.probe_status = changed_r ? ST_CHANGED : ST_UNCHANGED;
      else if (free_ok_r) out_nxt.probe_status = ST_NEW;
      else                out_nxt.probe_status = ST_FULL;
    end else if (cmd.rpt_fin) begin
      out_valid_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
      end else begin
        out_nxt.kind     = KIND_EMPTY;
        out_nxt.aged_out = aged_r;
        out_nxt.last     = 1'b1;
      end
    end else if (s1_vld_r && s1_phase_r == PH_RPT && ent_v && !full && pend_v_r) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
    end
  end

  // Control and walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      s1_vld_r    <= 1'b0;
      valid_r     <= '0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      aged_r      <= 1'b0;
      mcnt_r      <= '0;
      rcnt_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      s1_vld_r    <= cmd.issue;
      if (cmd.accept) begin
        idx_r     <= '0;
        found_r   <= 1'b0;
        free_ok_r <= 1'b0;
        aged_r    <= 1'b0;
        mcnt_r    <= (cfg.master == MASTER_ON) ? 2'd1 : 2'd0;
        rcnt_r    <= '0;
        pend_v_r  <= 1'b0;
      end else if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.pwrite && (found_r || free_ok_r)) begin
        valid_r[found_r ? slot_r : free_r] <= 1'b1;
      end
      if (s1_vld_r && ent_v) begin
        unique case (s1_phase_r)
          PH_SCAN: begin
            if (!found_r && rd_r.node == item_r.node_no) found_r <= 1'b1;
          end
          PH_AGE: begin
            if (expire) begin
              valid_r[s1_idx_r] <= 1'b0;
              aged_r            <= 1'b1;
            end else if (pmatch && rd_r.master == MASTER_ON && mcnt_r != 2'd2) begin
              mcnt_r <= mcnt_r + 2'd1;
            end
          end
          PH_RPT: begin
            if (!full) begin
              pend_v_r <= 1'b1;
              rcnt_r   <= rcnt_r + RCW'(1);
            end
          end
          default: ;
        endcase
      end
      if (s1_vld_r && !ent_v && s1_phase_r == PH_SCAN && !free_ok_r) begin
        free_ok_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_item;
    s1_phase_r <= cmd.phase;
    s1_idx_r   <= idx_r[IW-1:0];
    out_r      <= out_nxt;
    if (s1_vld_r && ent_v && s1_phase_r == PH_SCAN && !found_r &&
        rd_r.node == item_r.node_no) begin
      slot_r    <= s1_idx_r;
      changed_r <= differs;
    end
    if (s1_vld_r && !ent_v && s1_phase_r == PH_SCAN && !free_ok_r) begin
      free_r <= s1_idx_r;
    end
    if (s1_vld_r && ent_v && s1_phase_r == PH_RPT && !full) begin
      pend_r <= peer_item;
    end
  end

  always_comb begin
    sts.is_tick    = item_r.operation;
    sts.fmt_bad    = (item_r.format_version != FMT_VERSION) ||
                     (item_r.radio_kind != RADIO_KIND);
    sts.own        = item_r.node_no == cfg.node;
    sts.issue_done = idx_r == CW'(TABLE_ENTRIES);
    sts.pipe_busy  = s1_vld_r;
    sts.rpt_full   = full;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/core/ntamc_ctrl.sv
// ----------------------------------------------------------------------------
// ntamc_ctrl
// Sequencer: checks a probe, walks the table for lookup, aging and reports.
// ----------------------------------------------------------------------------
module ntamc_ctrl import ntamc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PWR  = 3'd3;
  localparam logic [2:0] S_AGE  = 3'd4;
  localparam logic [2:0] S_RPT  = 3'd5;
  localparam logic [2:0] S_RFIN = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.phase = PH_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.is_tick) begin
          state_nxt = S_AGE;
        end else if (sts.fmt_bad || sts.own) begin
          cmd.emit_early = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = !sts.issue_done;
        if (sts.issue_done && !sts.pipe_busy) state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.pwrite = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_AGE: begin
        cmd.phase = PH_AGE;
        cmd.issue = !sts.issue_done;
        if (sts.issue_done && !sts.pipe_busy) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_RPT;
        end
      end
      S_RPT: begin
        cmd.phase = PH_RPT;
        cmd.issue = !sts.issue_done && !sts.rpt_full;
        if ((sts.issue_done || sts.rpt_full) && !sts.pipe_busy) state_nxt = S_RFIN;
      end
      S_RFIN: begin
        cmd.rpt_fin = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule
